// ===== rtl/core/rrs_pkg.sv =====
`timescale 1ns / 1ps

package rrs_pkg;

    // Field widths fixed by the interface.
    localparam int ID_W    = 4;
    localparam int NUM_IDS = 16;
    localparam int TIME_W  = 32;
    localparam int LEN_W   = 16;
    localparam int ALU_W   = TIME_W + 2;

    // Reset value of the time slice register.
    localparam logic [LEN_W-1:0] QUANTUM_RESET = 16'd4;

    // Command codes.
    localparam logic OP_ADMIT = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // Event codes.
    localparam logic [1:0] EV_START   = 2'd0;
    localparam logic [1:0] EV_FINISH  = 2'd1;
    localparam logic [1:0] EV_PREEMPT = 2'd2;

    // Command beat.
    typedef struct packed {
        logic              op;
        logic [TIME_W-1:0] now;
        logic [ID_W-1:0]   task_id;
        logic [LEN_W-1:0]  burst;
    } req_t;

    // Result beat.
    typedef struct packed {
        logic [1:0]        event_res;
        logic [ID_W-1:0]   who;
        logic [TIME_W-1:0] at_time;
        logic [TIME_W-1:0] turnaround;
        logic [TIME_W-1:0] waiting;
        logic [TIME_W-1:0] response;
        logic              last;
    } rsp_t;

    // One row of the per-task table.
    typedef struct packed {
        logic [LEN_W-1:0]  rem;
        logic [LEN_W-1:0]  blen;
        logic [TIME_W-1:0] arrival;
        logic              first_valid;
        logic [TIME_W-1:0] first_start;
    } task_row_t;

    // Operands and mode of the shared adder.
    typedef struct packed {
        logic             sub;
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
    } alu_req_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_END,
        ST_CMP,
        ST_DEC,
        ST_TA,
        ST_WT,
        ST_RS,
        ST_PICK,
        ST_POPW,
        ST_START
    } state_t;

endpackage

// ===== rtl/core/rrs_alu.sv =====
`timescale 1ns / 1ps

module rrs_alu (
    input  rrs_pkg::alu_req_t             alu_req,
    output logic [rrs_pkg::ALU_W-1:0]     alu_res
);
    import rrs_pkg::*;

    logic [ALU_W-1:0] b_op;

    // Add, or subtract by adding the inverted operand plus one.
    assign b_op    = alu_req.sub ? ~alu_req.b : alu_req.b;
    assign alu_res = alu_req.a + b_op + {{(ALU_W-1){1'b0}}, alu_req.sub};

endmodule

// ===== rtl/core/round_robin_task_scheduler.sv =====
`timescale 1ns / 1ps
// Admit: taken while idle, busy stays low, no result.
// Tick: the block goes busy; every add, subtract and compare goes through one
// shared 34-bit adder, one operation per cycle, and table and queue reads are registered.
// Results appear one per cycle on result_valid; the receiver cannot stall them.
// Reset (rst_n low, asynchronous): queue empty, no running or held task, quantum 4.
module round_robin_task_scheduler #(
    parameter int MAX_TASKS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  rrs_pkg::req_t                req,
    output logic                         result_valid,
    output rrs_pkg::rsp_t                result,
    input  logic                         quantum_we,
    input  logic [rrs_pkg::LEN_W-1:0]    quantum_wdata
);
    import rrs_pkg::*;

    localparam int PTR_W = $clog2(MAX_TASKS);
    localparam int CNT_W = $clog2(MAX_TASKS + 1);
    localparam int SUM_W = CNT_W + 1;

    // Storage.
    task_row_t        task_mem [NUM_IDS];
    logic [ID_W-1:0]  fifo_mem [MAX_TASKS];

    // Control and payload registers.
    state_t            state_reg, state_next;
    logic [LEN_W-1:0]  quantum_reg;
    logic [PTR_W-1:0]  head_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              held_valid_reg;
    logic [ID_W-1:0]   held_id_reg;
    logic              run_valid_reg;
    logic [ID_W-1:0]   run_id_reg;
    logic [TIME_W-1:0] slice_start_reg;
    logic              result_valid_reg;
    logic [TIME_W-1:0] now_reg;
    logic [ID_W-1:0]   nx_reg;
    logic [TIME_W:0]   acc_reg;
    logic              lt_reg;
    logic [TIME_W-1:0] ta_reg;
    logic [TIME_W-1:0] wt_reg;
    task_row_t         row_reg;
    logic [ID_W-1:0]   fifo_rd_reg;
    rsp_t              result_reg;

    // Combinational control.
    logic              accept, tick_go, admit_ok;
    alu_req_t          alu_req;
    logic [ALU_W-1:0]  alu_res;
    logic              tm_we, tm_re;
    logic [ID_W-1:0]   tm_waddr, tm_raddr;
    task_row_t         tm_wdata;
    logic              ff_we, ff_re, push, pop;
    logic [ID_W-1:0]   ff_wdata;
    logic              emit;
    rsp_t              emit_data;
    logic [LEN_W-1:0]  new_rem;
    logic              fin, pre;
    logic [SUM_W-1:0]  tail_sum, tail_wrap;
    logic [PTR_W-1:0]  tail;
    logic [PTR_W-1:0]  head_inc;

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    assign accept   = start && !busy;
    assign tick_go  = accept && (req.op == OP_TICK);
    assign admit_ok = accept && (req.op == OP_ADMIT)
                      && (32'(req.task_id) < MAX_TASKS)
                      && (32'(count_reg) + 32'(held_valid_reg) < MAX_TASKS);

    // Queue tail and head wrap.
    assign tail_sum  = SUM_W'(head_reg) + SUM_W'(count_reg);
    assign tail_wrap = (tail_sum >= SUM_W'(MAX_TASKS)) ? tail_sum - SUM_W'(MAX_TASKS)
                                                       : tail_sum;
    assign tail      = tail_wrap[PTR_W-1:0];
    assign head_inc  = (head_reg == PTR_W'(MAX_TASKS - 1)) ? '0 : head_reg + PTR_W'(1);

    // Shared adder.
    rrs_alu u_alu (
        .alu_req (alu_req),
        .alu_res (alu_res)
    );

    // Work and slice decision for the running task.
    always_comb
    begin
        new_rem = row_reg.rem;
        if ((row_reg.rem != '0) && lt_reg)
        begin
            new_rem = alu_res[LEN_W-1:0];
        end
        fin = (new_rem == '0);
        pre = !fin && !lt_reg;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (tick_go)
                begin
                    state_next = run_valid_reg ? ST_END : ST_PICK;
                end
            end
            ST_END:   state_next = ST_CMP;
            ST_CMP:   state_next = ST_DEC;
            ST_DEC:
            begin
                if (fin)
                begin
                    state_next = ST_TA;
                end
                else if (pre)
                begin
                    state_next = ST_PICK;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_TA:    state_next = ST_WT;
            ST_WT:    state_next = ST_RS;
            ST_RS:    state_next = ST_PICK;
            ST_PICK:
            begin
                if (count_reg != '0)
                begin
                    state_next = ST_POPW;
                end
                else if (held_valid_reg)
                begin
                    state_next = ST_START;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_POPW:  state_next = ST_START;
            ST_START: state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Datapath control per state.
    always_comb
    begin
        alu_req   = '0;
        tm_we     = 1'b0;
        tm_waddr  = run_id_reg;
        tm_wdata  = row_reg;
        tm_re     = 1'b0;
        tm_raddr  = run_id_reg;
        ff_we     = 1'b0;
        ff_wdata  = held_id_reg;
        ff_re     = 1'b0;
        push      = 1'b0;
        pop       = 1'b0;
        emit      = 1'b0;
        emit_data = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (admit_ok)
                begin
                    tm_we                = 1'b1;
                    tm_waddr             = req.task_id;
                    tm_wdata.rem         = req.burst;
                    tm_wdata.blen        = req.burst;
                    tm_wdata.arrival     = req.now;
                    tm_wdata.first_valid = 1'b0;
                    tm_wdata.first_start = '0;
                    ff_we                = 1'b1;
                    ff_wdata             = req.task_id;
                    push                 = 1'b1;
                end
                if (tick_go)
                begin
                    if (held_valid_reg)
                    begin
                        ff_we = 1'b1;
                        push  = 1'b1;
                    end
                    tm_re = run_valid_reg;
                end
            end
            ST_END:
            begin
                alu_req.a = ALU_W'(slice_start_reg);
                alu_req.b = ALU_W'(quantum_reg);
            end
            ST_CMP:
            begin
                alu_req.sub = 1'b1;
                alu_req.a   = ALU_W'(now_reg);
                alu_req.b   = ALU_W'(acc_reg);
            end
            ST_DEC:
            begin
                alu_req.sub  = 1'b1;
                alu_req.a    = ALU_W'(row_reg.rem);
                alu_req.b    = ALU_W'(1);
                tm_we        = 1'b1;
                tm_wdata.rem = new_rem;
                if (pre)
                begin
                    emit                = 1'b1;
                    emit_data.event_res = EV_PREEMPT;
                    emit_data.who       = run_id_reg;
                    emit_data.at_time   = now_reg;
                end
            end
            ST_TA:
            begin
                alu_req.sub = 1'b1;
                alu_req.a   = ALU_W'(now_reg);
                alu_req.b   = ALU_W'(row_reg.arrival);
            end
            ST_WT:
            begin
                alu_req.sub = 1'b1;
                alu_req.a   = ALU_W'(ta_reg);
                alu_req.b   = ALU_W'(row_reg.blen);
            end
            ST_RS:
            begin
                alu_req.sub          = 1'b1;
                alu_req.a            = ALU_W'(row_reg.first_start);
                alu_req.b            = ALU_W'(row_reg.arrival);
                emit                 = 1'b1;
                emit_data.event_res  = EV_FINISH;
                emit_data.who        = run_id_reg;
                emit_data.at_time    = now_reg;
                emit_data.turnaround = ta_reg;
                emit_data.waiting    = wt_reg;
                emit_data.response   = alu_res[TIME_W-1:0];
                emit_data.last       = (count_reg == '0) && !held_valid_reg;
            end
            ST_PICK:
            begin
                if (count_reg != '0)
                begin
                    ff_re = 1'b1;
                    pop   = 1'b1;
                end
                else if (held_valid_reg)
                begin
                    tm_re    = 1'b1;
                    tm_raddr = held_id_reg;
                end
            end
            ST_POPW:
            begin
                tm_re    = 1'b1;
                tm_raddr = fifo_rd_reg;
            end
            ST_START:
            begin
                if (!row_reg.first_valid)
                begin
                    tm_we                = 1'b1;
                    tm_waddr             = nx_reg;
                    tm_wdata.first_valid = 1'b1;
                    tm_wdata.first_start = now_reg;
                    tm_wdata.rem         = row_reg.blen;
                end
                emit                = 1'b1;
                emit_data.event_res = EV_START;
                emit_data.who       = nx_reg;
                emit_data.at_time   = now_reg;
                emit_data.last      = 1'b1;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    // Per-task table.
    always_ff @(posedge clk)
    begin
        if (tm_we)
        begin
            task_mem[tm_waddr] <= tm_wdata;
        end
        if (tm_re)
        begin
            row_reg <= task_mem[tm_raddr];
        end
    end

    // Ready queue storage.
    always_ff @(posedge clk)
    begin
        if (ff_we)
        begin
            fifo_mem[tail] <= ff_wdata;
        end
        if (ff_re)
        begin
            fifo_rd_reg <= fifo_mem[head_reg];
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            quantum_reg      <= QUANTUM_RESET;
            head_reg         <= '0;
            count_reg        <= '0;
            held_valid_reg   <= 1'b0;
            run_valid_reg    <= 1'b0;
            slice_start_reg  <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= emit;
            if (quantum_we)
            begin
                quantum_reg <= quantum_wdata;
            end
            if (push)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (pop)
            begin
                count_reg <= count_reg - CNT_W'(1);
                head_reg  <= head_inc;
            end
            if (tick_go && held_valid_reg)
            begin
                held_valid_reg <= 1'b0;
            end
            else if ((state_reg == ST_DEC) && pre)
            begin
                held_valid_reg <= 1'b1;
            end
            else if ((state_reg == ST_PICK) && (count_reg == '0))
            begin
                held_valid_reg <= 1'b0;
            end
            if ((state_reg == ST_DEC) && (fin || pre))
            begin
                run_valid_reg <= 1'b0;
            end
            else if (state_reg == ST_START)
            begin
                run_valid_reg   <= 1'b1;
                slice_start_reg <= now_reg;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (tick_go)
        begin
            now_reg <= req.now;
        end
        if ((state_reg == ST_DEC) && pre)
        begin
            held_id_reg <= run_id_reg;
        end
        if (state_reg == ST_START)
        begin
            run_id_reg <= nx_reg;
        end
        if (state_reg == ST_PICK)
        begin
            nx_reg <= held_id_reg;
        end
        else if (state_reg == ST_POPW)
        begin
            nx_reg <= fifo_rd_reg;
        end
        if (state_reg == ST_END)
        begin
            acc_reg <= alu_res[TIME_W:0];
        end
        if (state_reg == ST_CMP)
        begin
            lt_reg <= alu_res[ALU_W-1];
        end
        if (state_reg == ST_TA)
        begin
            ta_reg <= alu_res[TIME_W-1:0];
        end
        if (state_reg == ST_WT)
        begin
            wt_reg <= alu_res[TIME_W-1:0];
        end
        if (emit)
        begin
            result_reg <= emit_data;
        end
    end

endmodule

// ===== rtl/core/rrs_checker.sv =====
`timescale 1ns / 1ps

module rrs_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          start,
    input logic          busy,
    input rrs_pkg::req_t req,
    input logic          result_valid,
    input rrs_pkg::rsp_t result
);
    import rrs_pkg::*;

    // A result beat only follows a cycle in which the sequencer was working.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
        else $error("result beat without a tick in progress");

    // A beat that is not the last of its tick leaves the block busy for the start beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.last) |-> busy)
        else $error("non-final beat but sequencer already idle");

    // A preemption is always followed by a dispatch on the same tick.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result.event_res == EV_PREEMPT)) |-> !result.last)
        else $error("preempt beat marked last");

    // An admit completes at once and never makes the block busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (req.op == OP_ADMIT)) |=> !busy)
        else $error("admit made the block busy");

    // Busy rises only for an accepted tick.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start && (req.op == OP_TICK)))
        else $error("busy rose without an accepted tick");

endmodule

bind round_robin_task_scheduler rrs_checker u_rrs_checker (.*);

// ===== dv/round_robin_task_scheduler_tb.sv =====
`timescale 1ns / 1ps

module round_robin_task_scheduler_tb;

    import rrs_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    // Idle long enough for the longest tick to finish.
    localparam int SETTLE_CYCLES = 16;

    // Tracks the scheduler state and holds the events each tick should emit.
    class schedule_tracker;
        logic [LEN_W-1:0]  quantum;
        logic [ID_W-1:0]   ready_q[$];
        bit                held_valid;
        logic [ID_W-1:0]   held_id;
        bit                run_valid;
        logic [ID_W-1:0]   run_id;
        logic [TIME_W-1:0] slice_start;
        logic [LEN_W-1:0]  rem_work[NUM_IDS];
        logic [LEN_W-1:0]  burst_len[NUM_IDS];
        logic [TIME_W-1:0] arrival[NUM_IDS];
        bit                first_seen[NUM_IDS];
        logic [TIME_W-1:0] first_time[NUM_IDS];
        rsp_t              due_events[$];
        int                errors;

        function new();
            quantum     = QUANTUM_RESET;
            held_valid  = 1'b0;
            held_id     = '0;
            run_valid   = 1'b0;
            run_id      = '0;
            slice_start = '0;
            errors      = 0;
            for (int i = 0; i < NUM_IDS; i++)
            begin
                rem_work[i]   = '0;
                burst_len[i]  = '0;
                arrival[i]    = '0;
                first_seen[i] = 1'b0;
                first_time[i] = '0;
            end
        endfunction

        function void enqueue(logic [ID_W-1:0] id);
            if (ready_q.size() < NUM_IDS)
                ready_q = {ready_q, id};
        endfunction

        function rsp_t make_event(logic [1:0] kind, logic [ID_W-1:0] id,
                                  logic [TIME_W-1:0] at, logic [TIME_W-1:0] ta,
                                  logic [TIME_W-1:0] wt, logic [TIME_W-1:0] rs);
            rsp_t ev;
            ev.event_res  = kind;
            ev.who        = id;
            ev.at_time    = at;
            ev.turnaround = ta;
            ev.waiting    = wt;
            ev.response   = rs;
            ev.last       = 1'b0;
            return ev;
        endfunction

        // Applies one accepted command beat; returns 0 if the block ignores it.
        function bit take_command(req_t cmd);
            rsp_t              ev[2];
            int                n;
            logic [TIME_W:0]   slice_end;
            logic [TIME_W-1:0] span;
            logic [ID_W-1:0]   nx;
            bit                got;
            n   = 0;
            got = 1'b0;
            nx  = '0;

            // Admit: record the task and queue it unless the queue is full.
            if (cmd.op == OP_ADMIT)
            begin
                if (ready_q.size() + held_valid >= NUM_IDS)
                    return 1'b0;
                rem_work[cmd.task_id]   = cmd.burst;
                burst_len[cmd.task_id]  = cmd.burst;
                arrival[cmd.task_id]    = cmd.now;
                first_seen[cmd.task_id] = 1'b0;
                first_time[cmd.task_id] = '0;
                enqueue(cmd.task_id);
                return 1'b1;
            end

            // A task preempted on the previous tick goes behind the admits.
            if (held_valid)
            begin
                enqueue(held_id);
                held_valid = 1'b0;
            end

            // Count work for the running task, then finish or preempt it.
            if (run_valid)
            begin
                slice_end = {1'b0, slice_start} + {{(TIME_W + 1 - LEN_W){1'b0}}, quantum};
                if (rem_work[run_id] != 0 && {1'b0, cmd.now} < slice_end)
                    rem_work[run_id] = rem_work[run_id] - 1'b1;
                if (rem_work[run_id] == 0)
                begin
                    span = cmd.now - arrival[run_id];
                    ev[n] = make_event(EV_FINISH, run_id, cmd.now, span,
                                       span - burst_len[run_id],
                                       first_time[run_id] - arrival[run_id]);
                    n++;
                    run_valid = 1'b0;
                end
                else if ({1'b0, cmd.now} >= slice_end)
                begin
                    ev[n] = make_event(EV_PREEMPT, run_id, cmd.now, '0, '0, '0);
                    n++;
                    held_id    = run_id;
                    held_valid = 1'b1;
                    run_valid  = 1'b0;
                end
            end

            // Dispatch the queue head, or the task just preempted if the queue is empty.
            if (!run_valid)
            begin
                if (ready_q.size() > 0)
                begin
                    nx  = ready_q.pop_front();
                    got = 1'b1;
                end
                else if (held_valid)
                begin
                    nx         = held_id;
                    held_valid = 1'b0;
                    got        = 1'b1;
                end
                if (got)
                begin
                    if (!first_seen[nx])
                    begin
                        first_seen[nx] = 1'b1;
                        first_time[nx] = cmd.now;
                        rem_work[nx]   = burst_len[nx];
                    end
                    run_id      = nx;
                    run_valid   = 1'b1;
                    slice_start = cmd.now;
                    ev[n] = make_event(EV_START, nx, cmd.now, '0, '0, '0);
                    n++;
                end
            end

            if (n > 0)
                ev[n-1].last = 1'b1;
            for (int k = 0; k < n; k++)
                due_events = {due_events, ev[k]};
            return 1'b1;
        endfunction

        function void compare_field(string name, logic [TIME_W-1:0] want,
                                    logic [TIME_W-1:0] seen);
            if (seen !== want)
            begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, seen);
                errors++;
            end
        endfunction

        // Compares one result beat against the oldest expected event.
        function void check_event(rsp_t seen);
            rsp_t want;
            if (due_events.size() == 0)
            begin
                $error("result beat with no event expected: event_res %0d who %0d",
                       seen.event_res, seen.who);
                errors++;
                return;
            end
            want = due_events.pop_front();
            compare_field("event_res", want.event_res, seen.event_res);
            compare_field("who", want.who, seen.who);
            compare_field("at_time", want.at_time, seen.at_time);
            compare_field("turnaround", want.turnaround, seen.turnaround);
            compare_field("waiting", want.waiting, seen.waiting);
            compare_field("response", want.response, seen.response);
            compare_field("last", want.last, seen.last);
        endfunction

        function int outstanding();
            return due_events.size();
        endfunction

        function int queued();
            return ready_q.size();
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n;
    logic              start;
    logic              busy;
    req_t              cmd_beat;
    logic              result_valid;
    rsp_t              result_beat;
    logic              quantum_we;
    logic [LEN_W-1:0]  quantum_wdata;

    schedule_tracker   tracker;
    int                cycle_count = 0;
    logic [TIME_W-1:0] sim_now;
    bit                calm;

    round_robin_task_scheduler u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .req           (cmd_beat),
        .result_valid  (result_valid),
        .result        (result_beat),
        .quantum_we    (quantum_we),
        .quantum_wdata (quantum_wdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Result beats cannot be stalled; check each one as it goes by.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && result_valid === 1'b1)
            tracker.check_event(result_beat);
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Presents one command beat from a falling edge, waits for it to be taken,
    // then holds start low for the given number of cycles.
    task automatic send(input logic op, input logic [TIME_W-1:0] at,
                        input logic [ID_W-1:0] id, input logic [LEN_W-1:0] len,
                        input int gap, output bit took);
        req_t cmd;
        cmd.op      = op;
        cmd.now     = at;
        cmd.task_id = id;
        cmd.burst   = len;
        start    <= 1'b1;
        cmd_beat <= cmd;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        took = tracker.take_command(cmd);
        @(negedge clk);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic admit(input logic [TIME_W-1:0] at, input logic [ID_W-1:0] id,
                         input logic [LEN_W-1:0] len);
        bit took;
        send(OP_ADMIT, at, id, len, 0, took);
    endtask

    task automatic tick(input logic [TIME_W-1:0] at);
        bit took;
        send(OP_TICK, at, '0, '0, 0, took);
    endtask

    // Waits until every expected event has come out and the block is quiet.
    task automatic settle();
        start <= 1'b0;
        while (tracker.outstanding() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_quantum(input logic [LEN_W-1:0] value);
        quantum_we    <= 1'b1;
        quantum_wdata <= value;
        @(negedge clk);
        quantum_we    <= 1'b0;
        tracker.quantum = value;
        @(negedge clk);
    endtask

    // Mostly admits and ticks in sensible proportions, with admit storms that
    // fill the queue, late ticks and occasional arbitrary time jumps.
    task automatic run_phase(input int count);
        int               done;
        int               storm;
        int               gap;
        int               pick;
        bit               is_admit;
        bit               took;
        logic [LEN_W-1:0] len;
        done  = 0;
        storm = 0;
        while (done < count)
        begin
            if ($urandom_range(0, 99) < 2)
                calm = !calm;
            gap = calm ? 0 : $urandom_range(0, 13);

            if (storm > 0)
            begin
                is_admit = 1'b1;
                storm--;
            end
            else if ($urandom_range(0, 99) < 3)
            begin
                is_admit = 1'b1;
                storm    = $urandom_range(8, 18);
            end
            else
                is_admit = $urandom_range(0, 99) < (tracker.queued() < 3 ? 45 : 12);

            if (is_admit)
            begin
                if ($urandom_range(0, 99) < 5)
                    len = LEN_W'($urandom_range(0, 65535));
                else
                    len = LEN_W'($urandom_range(1, 6));
                send(OP_ADMIT, sim_now, ID_W'($urandom_range(0, 15)), len, gap, took);
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 80)
                    sim_now = sim_now + 1;
                else if (pick < 97)
                    sim_now = sim_now + $urandom_range(2, 12);
                else
                    sim_now = $urandom;
                send(OP_TICK, sim_now, ID_W'($urandom_range(0, 15)),
                     LEN_W'($urandom_range(0, 65535)), gap, took);
            end
            if (took)
                done++;
        end
    endtask

    initial
    begin
        logic [LEN_W-1:0] phase_quantum[6];
        int               phase_items[6];

        tracker       = new();
        calm          = 1'b0;
        rst_n         = 1'b0;
        start         = 1'b0;
        cmd_beat      = '0;
        quantum_we    = 1'b0;
        quantum_wdata = '0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part at the reset quantum of four.
        // Zero burst finishes on the first tick after dispatch.
        admit(32'd0, 4'd0, 16'd0);
        admit(32'd0, 4'd15, 16'hFFFF);
        tick(32'd1);
        tick(32'd2);
        // Duplicate id while that task is running.
        admit(32'd3, 4'd15, 16'd2);
        tick(32'd3);
        tick(32'd4);
        tick(32'd5);
        // Late tick past the slice end, then the top of the time range.
        tick(32'd100);
        tick(32'hFFFF_FFFF);
        tick(32'hFFFF_FFFF);
        // Fill the queue; the last admit is turned away.
        for (int i = 0; i <= NUM_IDS; i++)
            admit(32'h8000_0000 | i, i[ID_W-1:0], 16'((i % 3) + 1));
        settle();

        phase_quantum = '{16'd1, 16'hFFFF, 16'd0, 16'd3, 16'd0, 16'd2};
        phase_quantum[4] = LEN_W'($urandom_range(2, 10));
        phase_items   = '{250, 250, 50, 250, 250, 250};
        sim_now = 32'd200;
        for (int p = 0; p < 6; p++)
        begin
            write_quantum(phase_quantum[p]);
            run_phase(phase_items[p]);
            settle();
        end

        if (tracker.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
